/* rtl/core/cjrd_pkg.sv */
// Shared types and constants of the command journal record decoder.
package cjrd_pkg;

	// Parser phase within one journal buffer.
	typedef enum logic [2:0] {
		PH_COUNT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_STATUS,
		PH_ID,
		PH_TAIL
	} phase_t;

	// Record kinds.
	localparam logic KIND_ID      = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Largest legal status byte.
	localparam logic [7:0] STATUS_MAX = 8'd3;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID_BYTES = 1'd1;
	localparam logic [7:0]  MAX_ENTRIES_RST  = 8'd16;
	localparam logic [15:0] MAX_ID_BYTES_RST = 16'd64;

	// Result queue geometry.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_CW    = 3;

	// One result record.
	typedef struct packed {
		logic        kind;
		logic [7:0]  entry_index;
		logic [15:0] byte_index;
		logic [7:0]  id_byte;
		logic [15:0] id_length;
		logic [1:0]  status_code;
		logic        entry_done;
		logic        ok;
		logic        last_of_run;
	} result_t;

	// What one parser step produces: up to an identifier record and a verdict.
	typedef struct packed {
		logic    id_valid;
		logic    verdict_valid;
		result_t id_rec;
		result_t verdict_rec;
	} step_t;

endpackage

/* rtl/core/cjrd_in_if.sv */
// Byte stream channel into the journal decoder.
interface cjrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

/* rtl/core/cjrd_out_if.sv */
// Record channel out of the journal decoder.
interface cjrd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  entry_index;
	logic [15:0] byte_index;
	logic [7:0]  id_byte;
	logic [15:0] id_length;
	logic [1:0]  status_code;
	logic        entry_done;
	logic        ok;
	logic        last_of_run;

	modport source (output valid, output kind, output entry_index, output byte_index,
		output id_byte, output id_length, output status_code, output entry_done,
		output ok, output last_of_run, input ready);
	modport sink (input valid, input kind, input entry_index, input byte_index,
		input id_byte, input id_length, input status_code, input entry_done,
		input ok, input last_of_run, output ready);
endinterface

/* rtl/core/command_journal_record_decoder.sv */
// Top level of the command journal record decoder.
//
// The journal channel carries one buffer byte per transfer, with end_of_buffer
// set on the last byte of a buffer. The first byte of a buffer is the entry
// count; each entry then has a little-endian 16-bit identifier length, a status
// byte and the identifier bytes. Every identifier byte leaves on the record
// channel as an identifier record, and the last byte of a buffer also yields a
// verdict record (ok set when the buffer is well formed). Header bytes and
// bytes after an error yield no record. The write port sets max_entries and
// max_id_bytes; the user writes it only while the decoder is idle, not enforced.
//
// An accepted byte waits in the input register until the queue has room for
// two records; it is then parsed and its records are written into a four-entry
// result queue. One byte is taken per cycle while the queue has room.
// With a receiver that is always ready the input never stalls:
// a buffer adds at most one record beyond one per byte, and its header bytes,
// which yield none, drain that surplus before the next buffer ends. When the
// receiver stalls the queue fills and the journal channel drops ready. Reset
// clears the parser, empties the queue and loads max_entries 16 and max_id_bytes 64.
module command_journal_record_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	cjrd_in_if.sink                             journal,
	cjrd_out_if.source                          record,
	input  logic                                wr_en,
	input  logic [cjrd_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [cjrd_pkg::CFG_DATA_W-1:0]     wr_data
);

	logic [7:0]  max_entries_q;
	logic [15:0] max_id_bytes_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eob_s1;

	// Result queue.
	cjrd_pkg::result_t                  queue_q [cjrd_pkg::QUEUE_DEPTH];
	logic [cjrd_pkg::QUEUE_AW-1:0]      wr_ptr_q, rd_ptr_q, wr_next;
	logic [cjrd_pkg::QUEUE_CW-1:0]      count_q;
	logic [1:0]                         push_n;
	logic                               pop;

	cjrd_pkg::step_t   step_res;
	cjrd_pkg::result_t head;
	logic              fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q  <= cjrd_pkg::MAX_ENTRIES_RST;
			max_id_bytes_q <= cjrd_pkg::MAX_ID_BYTES_RST;
		end else if (wr_en) begin
			case (wr_index)
				cjrd_pkg::CFG_MAX_ENTRIES:  max_entries_q  <= wr_data[7:0];
				cjrd_pkg::CFG_MAX_ID_BYTES: max_id_bytes_q <= wr_data;
				default: ;
			endcase
		end
	end

	// The held byte is parsed only when the queue has room for two records,
	// judged from the registered count so that ready does not depend on the
	// receiver in the same cycle.
	assign fire          = valid_s1 && (count_q <= cjrd_pkg::QUEUE_CW'(cjrd_pkg::QUEUE_DEPTH - 2));
	assign journal.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (journal.ready) begin
			valid_s1 <= journal.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (journal.valid && journal.ready) begin
			data_s1 <= journal.data_byte;
			eob_s1  <= journal.end_of_buffer;
		end
	end

	cjrd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (fire),
		.data_byte     (data_s1),
		.end_of_buffer (eob_s1),
		.max_entries   (max_entries_q),
		.max_id_bytes  (max_id_bytes_q),
		.result        (step_res)
	);

	// An identifier record goes ahead of the verdict of the same byte.
	assign push_n  = fire ? ({1'b0, step_res.id_valid} + {1'b0, step_res.verdict_valid}) : 2'd0;
	assign wr_next = wr_ptr_q + cjrd_pkg::QUEUE_AW'(1);
	assign pop     = record.valid && record.ready;

	always_ff @(posedge clk) begin
		if (fire) begin
			if (step_res.id_valid) begin
				queue_q[wr_ptr_q] <= step_res.id_rec;
			end
			if (step_res.verdict_valid) begin
				if (step_res.id_valid) begin
					queue_q[wr_next] <= step_res.verdict_rec;
				end else begin
					queue_q[wr_ptr_q] <= step_res.verdict_rec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cjrd_pkg::QUEUE_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cjrd_pkg::QUEUE_AW'(1);
			end
			count_q <= count_q + cjrd_pkg::QUEUE_CW'(push_n) - cjrd_pkg::QUEUE_CW'(pop);
		end
	end

	assign head               = queue_q[rd_ptr_q];
	assign record.valid       = (count_q != '0);
	assign record.kind        = head.kind;
	assign record.entry_index = head.entry_index;
	assign record.byte_index  = head.byte_index;
	assign record.id_byte     = head.id_byte;
	assign record.id_length   = head.id_length;
	assign record.status_code = head.status_code;
	assign record.entry_done  = head.entry_done;
	assign record.ok          = head.ok;
	assign record.last_of_run = head.last_of_run;

	// The queue never holds more records than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cjrd_pkg::QUEUE_CW'(cjrd_pkg::QUEUE_DEPTH))
		else $error("result queue over capacity");

	// A parsed byte always finds room for all of its records.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> ({1'b0, count_q} + {2'b0, push_n}) <= (cjrd_pkg::QUEUE_CW + 1)'(cjrd_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// A verdict record always closes the run of its byte.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(record.valid && record.kind == cjrd_pkg::KIND_VERDICT) |-> record.last_of_run)
		else $error("verdict record not last of run");

	// Identifier records never carry a verdict.
	a_id_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(record.valid && record.kind == cjrd_pkg::KIND_ID) |-> !record.ok)
		else $error("identifier record with ok set");

endmodule

/* rtl/core/cjrd_parser.sv */
// Journal parser state and the per-byte step logic.
module cjrd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_buffer,
	input  logic [7:0]            max_entries,
	input  logic [15:0]           max_id_bytes,
	output cjrd_pkg::step_t       result
);

	cjrd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  entries_left_q, entries_left_d;
	logic [7:0]  current_entry_q, current_entry_d;
	logic [7:0]  length_low_q, length_low_d;
	logic [15:0] current_length_q, current_length_d;
	logic [15:0] bytes_taken_q, bytes_taken_d;
	logic [1:0]  current_status_q, current_status_d;
	logic        error_q, error_d;
	logic [16:0] taken_inc;
	logic        done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= cjrd_pkg::PH_COUNT;
			entries_left_q   <= '0;
			current_entry_q  <= '0;
			length_low_q     <= '0;
			current_length_q <= '0;
			bytes_taken_q    <= '0;
			current_status_q <= '0;
			error_q          <= 1'b0;
		end else if (step) begin
			phase_q          <= phase_d;
			entries_left_q   <= entries_left_d;
			current_entry_q  <= current_entry_d;
			length_low_q     <= length_low_d;
			current_length_q <= current_length_d;
			bytes_taken_q    <= bytes_taken_d;
			current_status_q <= current_status_d;
			error_q          <= error_d;
		end
	end

	assign taken_inc = {1'b0, bytes_taken_q} + 17'd1;
	assign done      = (taken_inc == {1'b0, current_length_q});

	always_comb begin
		phase_d          = phase_q;
		entries_left_d   = entries_left_q;
		current_entry_d  = current_entry_q;
		length_low_d     = length_low_q;
		current_length_d = current_length_q;
		bytes_taken_d    = bytes_taken_q;
		current_status_d = current_status_q;
		error_d          = error_q;
		result           = '0;

		if (!error_q) begin
			case (phase_q)
				cjrd_pkg::PH_COUNT: begin
					if (data_byte > max_entries) begin
						error_d = 1'b1;
					end else begin
						entries_left_d  = data_byte;
						current_entry_d = '0;
						phase_d = (data_byte == 8'd0) ? cjrd_pkg::PH_TAIL : cjrd_pkg::PH_LEN_LO;
					end
				end
				cjrd_pkg::PH_LEN_LO: begin
					length_low_d = data_byte;
					phase_d      = cjrd_pkg::PH_LEN_HI;
				end
				cjrd_pkg::PH_LEN_HI: begin
					current_length_d = {data_byte, length_low_q};
					phase_d          = cjrd_pkg::PH_STATUS;
				end
				cjrd_pkg::PH_STATUS: begin
					if (current_length_q == 16'd0 || current_length_q > max_id_bytes
							|| data_byte > cjrd_pkg::STATUS_MAX) begin
						error_d = 1'b1;
					end else begin
						current_status_d = data_byte[1:0];
						bytes_taken_d    = '0;
						phase_d          = cjrd_pkg::PH_ID;
					end
				end
				cjrd_pkg::PH_ID: begin
					result.id_valid                = 1'b1;
					result.id_rec.kind             = cjrd_pkg::KIND_ID;
					result.id_rec.entry_index      = current_entry_q;
					result.id_rec.byte_index       = bytes_taken_q;
					result.id_rec.id_byte          = data_byte;
					result.id_rec.id_length        = current_length_q;
					result.id_rec.status_code      = current_status_q;
					result.id_rec.entry_done       = done;
					result.id_rec.last_of_run      = !end_of_buffer;
					bytes_taken_d = taken_inc[15:0];
					if (done) begin
						current_entry_d = current_entry_q + 8'd1;
						entries_left_d  = entries_left_q - 8'd1;
						phase_d = (entries_left_q == 8'd1) ? cjrd_pkg::PH_TAIL
							: cjrd_pkg::PH_LEN_LO;
					end
				end
				default: begin
					// Any byte after the last entry is trailing garbage.
					error_d = 1'b1;
				end
			endcase
		end

		if (end_of_buffer) begin
			result.verdict_valid           = 1'b1;
			result.verdict_rec.kind        = cjrd_pkg::KIND_VERDICT;
			result.verdict_rec.ok          = !error_d && (phase_d == cjrd_pkg::PH_TAIL);
			result.verdict_rec.last_of_run = 1'b1;
			phase_d          = cjrd_pkg::PH_COUNT;
			entries_left_d   = '0;
			current_entry_d  = '0;
			length_low_d     = '0;
			current_length_d = '0;
			bytes_taken_d    = '0;
			current_status_d = '0;
			error_d          = 1'b0;
		end
	end

endmodule
